// ----- design/prl_pkg.sv -----
`timescale 1ns / 1ps
package prl_pkg;
    localparam int NumCallersDefault   = 16;
    localparam int MaxPerWindowDefault = 8;
    localparam int TimeBitsDefault     = 48;
    localparam logic [2:0] LevelCap    = 3'd5;
    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_MAX_PER  = 2'd1;
    localparam logic [1:0] CFG_BASE     = 2'd2;
    localparam logic [1:0] CFG_MAX_BACK = 2'd3;
endpackage

// ----- design/prl_front.sv -----
`timescale 1ns / 1ps
module prl_front #(
    parameter int NUM_CALLERS = prl_pkg::NumCallersDefault,
    parameter int TIME_BITS   = prl_pkg::TimeBitsDefault,
    localparam int CW = (NUM_CALLERS > 1) ? $clog2(NUM_CALLERS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           in_caller,
    input  logic [TIME_BITS-1:0] in_now,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [CW-1:0]        q_caller,
    output logic [TIME_BITS-1:0] q_now
);
    import prl_pkg::*;
    // two entry queue between front and back
    logic [1:0]           cnt_reg;
    logic                 wp_reg, rp_reg;
    logic [CW-1:0]        c_reg [2];
    logic [TIME_BITS-1:0] t_reg [2];
    logic [CW-1:0]        cmod;
    logic                 push, pop;

    // caller index reduced by a small constant lookup over the 16 codes
    always_comb
    begin
        cmod = '0;
        for (int k = 0; k < 16; k++)
            if (in_caller == 4'(k))
                cmod = CW'(k % NUM_CALLERS);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_caller = c_reg[rp_reg];
    assign q_now    = t_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            c_reg[wp_reg] <= cmod;
            t_reg[wp_reg] <= in_now;
        end
    end
endmodule

// ----- design/prl_back.sv -----
`timescale 1ns / 1ps
module prl_back #(
    parameter int NUM_CALLERS    = prl_pkg::NumCallersDefault,
    parameter int MAX_PER_WINDOW = prl_pkg::MaxPerWindowDefault,
    parameter int TIME_BITS      = prl_pkg::TimeBitsDefault,
    localparam int CW = (NUM_CALLERS > 1) ? $clog2(NUM_CALLERS) : 1,
    localparam int SW = (MAX_PER_WINDOW > 1) ? $clog2(MAX_PER_WINDOW) : 1,
    localparam int NW = $clog2(MAX_PER_WINDOW + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [CW-1:0]        q_caller,
    input  logic [TIME_BITS-1:0] q_now,
    input  logic [31:0]          window_ticks,
    input  logic [3:0]           max_per_window,
    input  logic [31:0]          base_backoff_ticks,
    input  logic [31:0]          max_backoff_ticks,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 allowed
);
    import prl_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_RD = 3'd2, S_AGE = 3'd3,
                           S_DEC = 3'd4, S_BACK = 3'd5, S_END = 3'd6;
    localparam int DEPTH = NUM_CALLERS * MAX_PER_WINDOW;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = SW + 1;
    // wide enough for any time plus a 33 bit backoff length
    localparam int XW = ((TIME_BITS > 33) ? TIME_BITS : 33) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [TIME_BITS-1:0] rd_reg;
    logic [SW-1:0]        head_reg  [NUM_CALLERS];
    logic [NW-1:0]        count_reg [NUM_CALLERS];
    logic [2:0]           level_reg [NUM_CALLERS];
    logic [TIME_BITS-1:0] end_reg   [NUM_CALLERS];

    logic [2:0]           st_reg;
    logic [CW-1:0]        c_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [32:0]          len_reg;
    logic [2:0]           step_reg;
    logic                 ov_reg, al_reg;
    logic [XW-1:0]        sum_reg;

    logic [NW-1:0]        cnt_c;
    logic [SW-1:0]        head_c;
    logic [SW-1:0]        head_inc;
    logic [NW-1:0]        cap;
    logic [2:0]           lvl_n;
    logic [TIME_BITS-1:0] age;
    logic [33:0]          dbl;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [PW-1:0]        wsum;
    logic [SW-1:0]        wslot;

    assign cnt_c  = count_reg[c_reg];
    assign head_c = head_reg[c_reg];
    assign cap    = ({28'd0, max_per_window} < MAX_PER_WINDOW) ? NW'(max_per_window)
                                                               : NW'(MAX_PER_WINDOW);
    assign lvl_n  = (level_reg[c_reg] < LevelCap) ? level_reg[c_reg] + 3'd1 : LevelCap;
    assign age    = (now_reg >= rd_reg) ? now_reg - rd_reg : '0;
    assign dbl    = {len_reg, 1'b0};
    assign rd_addr = AW'(c_reg) * AW'(MAX_PER_WINDOW) + AW'(head_c);
    // ring slot arithmetic by compare and subtract
    assign head_inc = (head_c == SW'(MAX_PER_WINDOW - 1)) ? '0 : head_c + SW'(1);
    assign wsum   = {1'b0, head_c} + PW'(cnt_c);
    assign wslot  = (wsum >= PW'(MAX_PER_WINDOW)) ? SW'(wsum - PW'(MAX_PER_WINDOW))
                                                  : SW'(wsum);
    assign wr_addr = AW'(c_reg) * AW'(MAX_PER_WINDOW) + AW'(wslot);
    assign q_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_END);
    assign allowed = al_reg;

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (st_reg == S_DEC && cnt_c < cap)
            mem[wr_addr] <= now_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= XW'(now_reg) + XW'(len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            for (int i = 0; i < NUM_CALLERS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                level_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
            c_reg <= '0; now_reg <= '0; len_reg <= '0; step_reg <= '0;
            ov_reg <= 1'b0; al_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        c_reg   <= q_caller;
                        now_reg <= q_now;
                        st_reg  <= S_CHECK;
                    end
                S_CHECK:
                    if (end_reg[c_reg] > now_reg)
                    begin
                        al_reg <= 1'b0;
                        st_reg <= S_END;
                    end
                    else
                        st_reg <= S_RD;
                // ring slot read: wait for the registered slot time in rd_reg
                S_RD:
                    st_reg <= (cnt_c == '0) ? S_DEC : S_AGE;
                S_AGE:
                    if (cnt_c != '0 && XW'(age) > XW'(window_ticks))
                    begin
                        head_reg[c_reg]  <= head_inc;
                        count_reg[c_reg] <= cnt_c - NW'(1);
                        st_reg <= S_RD;
                    end
                    else
                        st_reg <= S_DEC;
                S_DEC:
                    if (cnt_c >= cap)
                    begin
                        level_reg[c_reg] <= lvl_n;
                        len_reg  <= {1'b0, base_backoff_ticks};
                        step_reg <= lvl_n;
                        al_reg   <= 1'b0;
                        ov_reg   <= 1'b0;
                        st_reg   <= S_BACK;
                    end
                    else
                    begin
                        count_reg[c_reg] <= cnt_c + NW'(1);
                        level_reg[c_reg] <= '0;
                        end_reg[c_reg]   <= '0;
                        al_reg <= 1'b1;
                        st_reg <= S_END;
                    end
                // one doubling per cycle, then a registered add
                S_BACK:
                    if (step_reg > 3'd1)
                    begin
                        len_reg  <= (dbl < {2'b0, max_backoff_ticks}) ? dbl[32:0]
                                                                      : {1'b0, max_backoff_ticks};
                        step_reg <= step_reg - 3'd1;
                    end
                    else if (!ov_reg)
                        ov_reg <= 1'b1;
                    else
                    begin
                        end_reg[c_reg] <= (sum_reg > XW'(TMAX)) ? TMAX
                                                                : sum_reg[TIME_BITS-1:0];
                        st_reg <= S_END;
                    end
                S_END:
                    if (out_ready)
                        st_reg <= S_IDLE;
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/per_caller_rate_limiter_core.sv -----
`timescale 1ns / 1ps
// per-caller rate limiter, sliding window with exponential backoff
// request channel: in_valid/in_ready with caller and now; a transfer
//   enqueues the request in a two entry queue in front of the back end
// result channel: out_valid/out_ready with allowed (1 accept, 0 reject)
// config channel: cfg_valid/cfg_ready, cfg_index 0..3 picks window,
//   per-window cap, base backoff, max backoff; always ready
// request steps: a request still in backoff is rejected after the end
//   time check; otherwise aged ring slots of the caller are dropped one by
//   one, then the count is checked and at the cap a new backoff is computed
//   (one doubling per cycle, then a registered add)
// occupancy: one request at a time in the back end, busy until its result is
//   taken; the ring walk and the backoff doublings set how long it is busy
// reset clears ring heads, counts, levels and end times and loads the
//   register defaults; ring time storage is not cleared
// when the receiver stalls the result holds and the queue keeps taking
//   up to two more requests before in_ready drops
module per_caller_rate_limiter_core #(
    parameter int NUM_CALLERS    = prl_pkg::NumCallersDefault,
    parameter int MAX_PER_WINDOW = prl_pkg::MaxPerWindowDefault,
    parameter int TIME_BITS      = prl_pkg::TimeBitsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           caller,
    input  logic [TIME_BITS-1:0] now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 allowed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import prl_pkg::*;
    localparam int CW = (NUM_CALLERS > 1) ? $clog2(NUM_CALLERS) : 1;

    logic [31:0]          window_reg, base_reg, maxb_reg;
    logic [3:0]           maxper_reg;
    logic                 q_valid, q_ready;
    logic [CW-1:0]        q_caller;
    logic [TIME_BITS-1:0] q_now;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd1000;
            maxper_reg <= 4'd5;
            base_reg   <= 32'd100;
            maxb_reg   <= 32'd3200;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW:   window_reg <= cfg_data;
                CFG_MAX_PER:  maxper_reg <= cfg_data[3:0];
                CFG_BASE:     base_reg   <= cfg_data;
                CFG_MAX_BACK: maxb_reg   <= cfg_data;
                default:      window_reg <= window_reg;
            endcase
        end
    end

    // front: request queue and caller index reduction
    prl_front #(.NUM_CALLERS(NUM_CALLERS), .TIME_BITS(TIME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_caller(caller), .in_now(now),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_caller(q_caller), .q_now(q_now)
    );

    // back: per-caller state, ring walk and backoff computation
    prl_back #(
        .NUM_CALLERS(NUM_CALLERS), .MAX_PER_WINDOW(MAX_PER_WINDOW), .TIME_BITS(TIME_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_caller(q_caller), .q_now(q_now),
        .window_ticks(window_reg), .max_per_window(maxper_reg),
        .base_backoff_ticks(base_reg), .max_backoff_ticks(maxb_reg),
        .out_valid(out_valid), .out_ready(out_ready), .allowed(allowed)
    );
endmodule
